/* src/assert_macros.svh */
// Assertion macros shared by the vector Holt smoother RTL.
// Depends on nothing; included by the files that carry assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check that is switched off while reset is asserted.
`define VHTS_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked check that also holds during reset.
`define VHTS_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* src/vhts_pkg.sv */
// Package of the vector Holt trend smoother: widths, codes and shared types.
// Depends on nothing; every other file but assert_macros.svh uses it.
package vhts_pkg;

    localparam int MAX_LANES  = 4;
    localparam int LANES      = 4;
    localparam int GAIN_BITS  = 16;
    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 16;
    localparam int STATE_W    = SAMPLE_W + FRAC_BITS;
    localparam int CFG_GAIN_W = 16;
    localparam int TOL_W      = 32;
    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    // Clamped gain runs from zero to exactly one, so it needs one more bit.
    localparam int GAIN_W  = GAIN_BITS + 1;
    localparam int DIFF_W  = STATE_W + 2;
    localparam int PROD_W  = DIFF_W + GAIN_W + 1;
    localparam int ACC_W   = PROD_W + 1;
    localparam int SQ_W    = 2 * (STATE_W + 1);
    localparam int SUM_W   = SQ_W + 2;
    localparam int TOLSQ_W = 2 * TOL_W;

    localparam logic [1:0] REG_LEVEL_GAIN = 2'd0;
    localparam logic [1:0] REG_TREND_GAIN = 2'd1;
    localparam logic [1:0] REG_HOLD_TOL   = 2'd2;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [STATE_W-1:0]  state_word_t;

    typedef struct packed {
        logic [CFG_GAIN_W-1:0] level_gain;
        logic [CFG_GAIN_W-1:0] trend_gain;
        logic [TOL_W-1:0]      hold_tolerance;
    } cfg_t;

    typedef struct packed {
        logic capture;
        logic load_first;
        logic mul;
        logic sel_trend;
        logic trend_upd;
        logic trend_init;
        logic level_upd;
        logic square;
        logic compare;
        logic out_load;
    } dp_cmd_t;

    typedef enum logic [1:0] {
        PHASE_FIRST,
        PHASE_SECOND,
        PHASE_STEADY
    } phase_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_TMUL,
        ST_TRND,
        ST_LMUL,
        ST_LRND,
        ST_SQUARE,
        ST_COMPARE,
        ST_OUT
    } ctrl_state_t;

endpackage

/* src/vhts_sample_if.sv */
// Input channel of the smoother: one vector sample per transfer.
// Depends on vhts_pkg for the lane sample type.
interface vhts_sample_if;
    logic             valid;
    logic             ready;
    vhts_pkg::sample_t sample_0;
    vhts_pkg::sample_t sample_1;
    vhts_pkg::sample_t sample_2;
    vhts_pkg::sample_t sample_3;

    modport source (output valid, output sample_0, output sample_1,
                    output sample_2, output sample_3, input ready);
    modport sink (input valid, input sample_0, input sample_1,
                  input sample_2, input sample_3, output ready);
endinterface

/* src/vhts_level_if.sv */
// Output channel of the smoother: one smoothed level vector per transfer.
// Depends on vhts_pkg for the state word type.
interface vhts_level_if;
    logic                  valid;
    logic                  ready;
    vhts_pkg::state_word_t level_0;
    vhts_pkg::state_word_t level_1;
    vhts_pkg::state_word_t level_2;
    vhts_pkg::state_word_t level_3;

    modport source (output valid, output level_0, output level_1,
                    output level_2, output level_3, input ready);
    modport sink (input valid, input level_0, input level_1,
                  input level_2, input level_3, output ready);
endinterface

/* src/vhts_regs.sv */
// APB register file of the smoother: the two gains and the hold tolerance.
// Depends on vhts_pkg for the register codes and the cfg_t bundle.
module vhts_regs (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vhts_pkg::ADDR_W-1:0] paddr,
    input  logic [vhts_pkg::DATA_W-1:0] pwdata,
    output logic [vhts_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    output vhts_pkg::cfg_t              cfg
);
    import vhts_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[3:2];
    assign cfg     = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_LEVEL_GAIN: cfg_next.level_gain     = pwdata[CFG_GAIN_W-1:0];
                REG_TREND_GAIN: cfg_next.trend_gain     = pwdata[CFG_GAIN_W-1:0];
                REG_HOLD_TOL:   cfg_next.hold_tolerance = pwdata[TOL_W-1:0];
                default:        cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_LEVEL_GAIN: prdata = DATA_W'(cfg_reg.level_gain);
            REG_TREND_GAIN: prdata = DATA_W'(cfg_reg.trend_gain);
            REG_HOLD_TOL:   prdata = DATA_W'(cfg_reg.hold_tolerance);
            default:        prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.level_gain     <= CFG_GAIN_W'(32768);
            cfg_reg.trend_gain     <= CFG_GAIN_W'(32768);
            cfg_reg.hold_tolerance <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end
endmodule

/* src/vhts_ctrl.sv */
// Sequencing state machine of the smoother: handshakes, phase and datapath commands.
// Depends on vhts_pkg and on assert_macros.svh for its checks.
`include "assert_macros.svh"

module vhts_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              samples_valid,
    output logic              samples_ready,
    output logic              levels_valid,
    input  logic              levels_ready,
    output vhts_pkg::dp_cmd_t cmd
);
    import vhts_pkg::*;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    phase_t      phase_reg;
    phase_t      phase_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        slot_free;

    assign slot_free     = !out_valid_reg || levels_ready;
    assign samples_ready = (state_reg == ST_IDLE);
    assign levels_valid  = out_valid_reg;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (samples_valid)
                begin
                    unique case (phase_reg)
                        PHASE_FIRST:  state_next = ST_LOAD;
                        PHASE_SECOND: state_next = ST_TRND;
                        PHASE_STEADY: state_next = ST_TMUL;
                        default:      state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD:    state_next = ST_OUT;
            ST_TMUL:    state_next = ST_TRND;
            ST_TRND:    state_next = ST_LMUL;
            ST_LMUL:    state_next = ST_LRND;
            ST_LRND:    state_next = ST_SQUARE;
            ST_SQUARE:  state_next = ST_COMPARE;
            ST_COMPARE: state_next = ST_OUT;
            ST_OUT:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    // Commands to the datapath.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            ST_IDLE:    cmd.capture = samples_valid;
            ST_LOAD:    cmd.load_first = 1'b1;
            ST_TMUL:
            begin
                cmd.mul       = 1'b1;
                cmd.sel_trend = 1'b1;
            end
            ST_TRND:
            begin
                cmd.trend_upd  = 1'b1;
                cmd.trend_init = (phase_reg == PHASE_SECOND);
            end
            ST_LMUL:    cmd.mul = 1'b1;
            ST_LRND:    cmd.level_upd = 1'b1;
            ST_SQUARE:  cmd.square = 1'b1;
            ST_COMPARE: cmd.compare = 1'b1;
            ST_OUT:     cmd.out_load = slot_free;
            default:    cmd = '0;
        endcase
    end

    // The phase moves on when the item's result is loaded.
    always_comb
    begin
        phase_next = phase_reg;
        if (cmd.out_load)
        begin
            unique case (phase_reg)
                PHASE_FIRST:  phase_next = PHASE_SECOND;
                PHASE_SECOND: phase_next = PHASE_STEADY;
                PHASE_STEADY: phase_next = PHASE_STEADY;
                default:      phase_next = PHASE_STEADY;
            endcase
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (levels_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_reg     <= PHASE_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            phase_reg     <= phase_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `VHTS_ASSERT(a_tmul_steady, clk, rst_n, (state_reg == ST_TMUL) |-> (phase_reg == PHASE_STEADY), "trend blend outside steady phase")
    `VHTS_ASSERT(a_out_waits, clk, rst_n, (state_reg == ST_OUT && out_valid_reg && !levels_ready) |=> (state_reg == ST_OUT), "result overwrote a pending transfer")
    `VHTS_ASSERT_ALWAYS(a_load_first, clk, (state_reg == ST_LOAD) |-> (phase_reg == PHASE_FIRST), "level load outside first phase")
endmodule

/* src/vhts_dp.sv */
// Lane datapath of the smoother: state registers, shared blend multipliers,
// squarers and the hold compare. Depends on vhts_pkg; driven by vhts_ctrl.
module vhts_dp (
    input  logic                  clk,
    input  vhts_pkg::dp_cmd_t     cmd,
    input  vhts_pkg::cfg_t        cfg,
    input  vhts_pkg::sample_t     sample_arr [vhts_pkg::MAX_LANES],
    output vhts_pkg::state_word_t level_arr  [vhts_pkg::MAX_LANES]
);
    import vhts_pkg::*;

    localparam int ONE  = 1 << GAIN_BITS;
    localparam int HALF = 1 << (GAIN_BITS - 1);
    localparam logic signed [ACC_W-1:0] SAT_MAX =
        {{(ACC_W-STATE_W+1){1'b0}}, {(STATE_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] SAT_MIN =
        {{(ACC_W-STATE_W+1){1'b1}}, {(STATE_W-1){1'b0}}};

    state_word_t x_reg     [MAX_LANES];
    state_word_t level_reg [MAX_LANES];
    state_word_t prev_reg  [MAX_LANES];
    state_word_t trend_reg [MAX_LANES];
    state_word_t out_reg   [MAX_LANES];
    logic signed [PROD_W-1:0]  prod_reg [MAX_LANES];
    logic signed [STATE_W:0]   base_reg [MAX_LANES];
    logic        [SQ_W-1:0]    sq_reg   [MAX_LANES];
    logic        [TOLSQ_W-1:0] tolsq_reg;

    logic        [GAIN_W-1:0]  alpha;
    logic        [GAIN_W-1:0]  beta;
    logic signed [GAIN_W:0]    gain_s;
    logic signed [STATE_W:0]   sum_lt   [MAX_LANES];
    logic signed [STATE_W:0]   dlev     [MAX_LANES];
    logic signed [DIFF_W-1:0]  mul_diff [MAX_LANES];
    logic signed [STATE_W:0]   mul_base [MAX_LANES];
    logic signed [PROD_W-1:0]  mul_prod [MAX_LANES];
    state_word_t               blend    [MAX_LANES];
    state_word_t               trend0   [MAX_LANES];
    logic signed [SQ_W-1:0]    sq_next  [MAX_LANES];
    logic        [SUM_W-1:0]   norm_sum;
    logic                      hold;

    function automatic state_word_t sat_acc(input logic signed [ACC_W-1:0] v);
        state_word_t r;
        if (v > SAT_MAX)
        begin
            r = SAT_MAX[STATE_W-1:0];
        end
        else if (v < SAT_MIN)
        begin
            r = SAT_MIN[STATE_W-1:0];
        end
        else
        begin
            r = v[STATE_W-1:0];
        end
        return r;
    endfunction

    // g*a + (ONE-g)*b is formed as g*(a-b) + ONE*b, then rounded half up.
    function automatic state_word_t round_blend(input logic signed [PROD_W-1:0] p,
                                                input logic signed [STATE_W:0] b);
        logic signed [ACC_W-1:0] acc;
        acc = ACC_W'(p) + (ACC_W'(b) <<< GAIN_BITS) + ACC_W'(HALF);
        return sat_acc(acc >>> GAIN_BITS);
    endfunction

    // A gain register above one can only occur when it is wider than GAIN_BITS; it clamps to one.
    assign alpha = (32'(cfg.level_gain) > 32'(ONE)) ? GAIN_W'(ONE) : GAIN_W'(cfg.level_gain);
    assign beta  = (32'(cfg.trend_gain) > 32'(ONE)) ? GAIN_W'(ONE) : GAIN_W'(cfg.trend_gain);
    assign gain_s = signed'({1'b0, (cmd.sel_trend ? beta : alpha)});

    always_comb
    begin
        for (int i = 0; i < MAX_LANES; i++)
        begin
            sum_lt[i] = (STATE_W+1)'(level_reg[i]) + (STATE_W+1)'(trend_reg[i]);
            dlev[i]   = (STATE_W+1)'(level_reg[i]) - (STATE_W+1)'(prev_reg[i]);
            if (cmd.sel_trend)
            begin
                mul_diff[i] = DIFF_W'(dlev[i]) - DIFF_W'(trend_reg[i]);
                mul_base[i] = (STATE_W+1)'(trend_reg[i]);
            end
            else
            begin
                mul_diff[i] = DIFF_W'(x_reg[i]) - DIFF_W'(sum_lt[i]);
                mul_base[i] = sum_lt[i];
            end
            mul_prod[i] = PROD_W'(gain_s) * PROD_W'(mul_diff[i]);
            blend[i]    = round_blend(prod_reg[i], base_reg[i]);
            trend0[i]   = sat_acc(ACC_W'((STATE_W+1)'(x_reg[i]) -
                                         (STATE_W+1)'(level_reg[i])));
            sq_next[i]  = SQ_W'(dlev[i]) * SQ_W'(dlev[i]);
        end
    end

    always_comb
    begin
        norm_sum = '0;
        for (int i = 0; i < LANES; i++)
        begin
            norm_sum = norm_sum + SUM_W'(sq_reg[i]);
        end
        // A zero tolerance gives a zero bound, so the strict compare never holds.
        hold = norm_sum < SUM_W'(tolsq_reg);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < LANES; i++)
        begin
            if (cmd.capture)
            begin
                x_reg[i] <= state_word_t'({sample_arr[i], {FRAC_BITS{1'b0}}});
            end
            if (cmd.mul)
            begin
                prod_reg[i] <= mul_prod[i];
                base_reg[i] <= mul_base[i];
            end
            if (cmd.trend_upd)
            begin
                trend_reg[i] <= cmd.trend_init ? trend0[i] : blend[i];
            end
            if (cmd.square)
            begin
                sq_reg[i] <= SQ_W'(sq_next[i]);
            end
            if (cmd.load_first)
            begin
                level_reg[i] <= x_reg[i];
            end
            else if (cmd.level_upd)
            begin
                prev_reg[i]  <= level_reg[i];
                level_reg[i] <= blend[i];
            end
            else if (cmd.compare && hold)
            begin
                level_reg[i] <= prev_reg[i];
            end
        end
        if (cmd.square)
        begin
            tolsq_reg <= TOLSQ_W'(cfg.hold_tolerance) * TOLSQ_W'(cfg.hold_tolerance);
        end
        for (int i = 0; i < MAX_LANES; i++)
        begin
            if (cmd.out_load)
            begin
                out_reg[i] <= (i < LANES) ? level_reg[i] : '0;
            end
        end
    end

    assign level_arr = out_reg;
endmodule

/* src/vector_holt_trend_smoother.sv */
// Vector Holt trend smoother: takes one sample vector per input transfer and
// returns one Q16.16 smoothed level vector per output transfer. The controller
// walks each steady-state item through the shared lane multipliers (trend blend,
// then level blend), a squarer stage and the norm compare; the second item
// takes its first difference as trend, the first only loads its level. A new
// sample waits until the last item is through, but results sit in an output
// register, so the next sample is taken while a finished level vector still
// waits to be transferred. State needs no clearing pass after reset.
module vector_holt_trend_smoother (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [vhts_pkg::ADDR_W-1:0] paddr,
    input  logic [vhts_pkg::DATA_W-1:0] pwdata,
    output logic [vhts_pkg::DATA_W-1:0] prdata,
    output logic                        pready,
    vhts_sample_if.sink                 samples,
    vhts_level_if.source                levels
);
    import vhts_pkg::*;

    cfg_t        cfg;
    dp_cmd_t     cmd;
    sample_t     sample_arr [MAX_LANES];
    state_word_t level_arr  [MAX_LANES];

    assign sample_arr[0] = samples.sample_0;
    assign sample_arr[1] = samples.sample_1;
    assign sample_arr[2] = samples.sample_2;
    assign sample_arr[3] = samples.sample_3;

    assign levels.level_0 = level_arr[0];
    assign levels.level_1 = level_arr[1];
    assign levels.level_2 = level_arr[2];
    assign levels.level_3 = level_arr[3];

    vhts_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    vhts_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .samples_valid (samples.valid),
        .samples_ready (samples.ready),
        .levels_valid  (levels.valid),
        .levels_ready  (levels.ready),
        .cmd           (cmd)
    );

    vhts_dp u_dp (
        .clk        (clk),
        .cmd        (cmd),
        .cfg        (cfg),
        .sample_arr (sample_arr),
        .level_arr  (level_arr)
    );
endmodule

/* sim/tb_vector_holt_trend_smoother.sv */
// Testbench of the vector Holt trend smoother: drives sample vectors and APB register
// writes, predicts every smoothed level vector and compares each output transfer with it.
// Depends on vhts_pkg, vhts_sample_if, vhts_level_if and vector_holt_trend_smoother.
module tb_vector_holt_trend_smoother;
    timeunit 1ns;
    timeprecision 1ps;

    import vhts_pkg::*;

    localparam int CYCLE_LIMIT  = 600000;
    localparam int DRAIN_CYCLES = 24;
    localparam int HOLD_OFF_LEN = 300;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    typedef logic [MAX_LANES-1:0][SAMPLE_W-1:0] sample_vec_t;
    typedef logic [MAX_LANES-1:0][STATE_W-1:0]  level_vec_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;
    logic              rx_ready = 1'b0;

    vhts_sample_if samples_ch();
    vhts_level_if  levels_ch();

    assign levels_ch.ready = rx_ready;

    vector_holt_trend_smoother dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .samples (samples_ch),
        .levels  (levels_ch)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Mirror of the smoother: register copies and per-lane state.
    logic [CFG_GAIN_W-1:0] alpha_cfg = 16'd32768;
    logic [CFG_GAIN_W-1:0] beta_cfg = 16'd32768;
    logic [TOL_W-1:0]      tol_cfg = '0;
    state_word_t           smooth_level [MAX_LANES];
    state_word_t           prior_level [MAX_LANES];
    state_word_t           trend_est [MAX_LANES];
    phase_t                smooth_phase = PHASE_FIRST;
    level_vec_t            expected_levels [$];

    int error_count = 0;
    int cycle_count = 0;
    int rx_hold_req = 0;
    int rx_hold_ack = 0;
    int rx_stall_left = 0;
    bit tx_quiet = 1'b0;
    bit rx_quiet = 1'b0;
    int drift_pos [MAX_LANES] = '{default: 0};
    int drift_step [MAX_LANES] = '{default: 0};

    function automatic state_word_t sat_word(input longint v);
        if (v > 64'sd2147483647)
            return {1'b0, {(STATE_W-1){1'b1}}};
        if (v < -64'sd2147483648)
            return {1'b1, {(STATE_W-1){1'b0}}};
        return v[STATE_W-1:0];
    endfunction

    function automatic longint clamp_gain(input logic [CFG_GAIN_W-1:0] g);
        longint unity;
        unity = longint'(1) <<< GAIN_BITS;
        return (longint'(g) > unity) ? unity : longint'(g);
    endfunction

    // g*a + (1-g)*b in exact precision, rounded half up, then saturated.
    function automatic state_word_t holt_blend(input longint g, input longint a,
                                               input longint b);
        longint acc;
        acc = g * a + ((longint'(1) <<< GAIN_BITS) - g) * b
            + (longint'(1) <<< (GAIN_BITS - 1));
        return sat_word(acc >>> GAIN_BITS);
    endfunction

    function automatic void advance_smoother(input sample_vec_t s);
        longint      alpha;
        longint      beta;
        longint      x;
        longint      delta;
        logic [69:0] step_mag;
        logic [69:0] norm;
        logic [69:0] tol_sq;
        level_vec_t  result;
        int          lane;
        alpha = clamp_gain(alpha_cfg);
        beta = clamp_gain(beta_cfg);
        norm = '0;
        for (lane = 0; lane < LANES; lane++)
        begin
            x = longint'($signed(s[lane])) * 65536;
            if (smooth_phase == PHASE_FIRST)
                smooth_level[lane] = x[STATE_W-1:0];
            else
            begin
                if (smooth_phase == PHASE_SECOND)
                    trend_est[lane] = sat_word(x - longint'(smooth_level[lane]));
                else
                    trend_est[lane] = holt_blend(beta,
                        longint'(smooth_level[lane]) - longint'(prior_level[lane]),
                        longint'(trend_est[lane]));
                prior_level[lane] = smooth_level[lane];
                smooth_level[lane] = holt_blend(alpha, x,
                    longint'(smooth_level[lane]) + longint'(trend_est[lane]));
                delta = longint'(smooth_level[lane]) - longint'(prior_level[lane]);
                step_mag = 70'(delta < 0 ? -delta : delta);
                norm = norm + step_mag * step_mag;
            end
        end
        if (smooth_phase != PHASE_FIRST)
        begin
            // The trend update stands even when the level is held.
            tol_sq = 70'(tol_cfg) * 70'(tol_cfg);
            if (norm < tol_sq)
                for (lane = 0; lane < LANES; lane++)
                    smooth_level[lane] = prior_level[lane];
        end
        if (smooth_phase == PHASE_FIRST)
            smooth_phase = PHASE_SECOND;
        else
            smooth_phase = PHASE_STEADY;
        for (lane = 0; lane < MAX_LANES; lane++)
            result[lane] = (lane < LANES) ? smooth_level[lane] : '0;
        expected_levels.push_back(result);
    endfunction

    function automatic int pick_gap(input bit quiet);
        int roll;
        roll = $urandom_range(99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic sample_vec_t make_vec(input int l0, input int l1, input int l2,
                                             input int l3);
        sample_vec_t s;
        s[0] = l0[15:0];
        s[1] = l1[15:0];
        s[2] = l2[15:0];
        s[3] = l3[15:0];
        return s;
    endfunction

    // Mostly slow ramps with small noise per lane, the rest full-range noise and corners.
    function automatic sample_vec_t next_random_sample();
        sample_vec_t s;
        int          roll;
        int          lane;
        int          v;
        roll = $urandom_range(99);
        for (lane = 0; lane < MAX_LANES; lane++)
        begin
            if (roll < 70)
            begin
                if ($urandom_range(15) == 0)
                    drift_step[lane] = int'($urandom_range(400)) - 200;
                v = drift_pos[lane] + drift_step[lane] + int'($urandom_range(6)) - 3;
                if (v > 32767 || v < -32768)
                begin
                    drift_step[lane] = -drift_step[lane];
                    v = drift_pos[lane];
                end
                drift_pos[lane] = v;
                s[lane] = v[15:0];
            end
            else if (roll < 90)
                s[lane] = 16'($urandom);
            else
                case ($urandom_range(3))
                    0: s[lane] = 16'h7FFF;
                    1: s[lane] = 16'h8000;
                    2: s[lane] = 16'h0000;
                    default: s[lane] = 16'hFFFF;
                endcase
        end
        return s;
    endfunction

    function automatic logic [CFG_GAIN_W-1:0] random_gain();
        case ($urandom_range(5))
            0: return 16'd1;
            1: return 16'hFFFF;
            default: return 16'($urandom_range(1, 65535));
        endcase
    endfunction

    function automatic logic [TOL_W-1:0] random_tolerance();
        case ($urandom_range(5))
            0: return '0;
            1: return '1;
            2: return $urandom_range(1, 1 << 18);
            3: return $urandom_range(1 << 18, 1 << 24);
            default: return $urandom;
        endcase
    endfunction

    // Setup and access cycle; psel stays high when another write follows.
    task automatic write_register(input logic [1:0] idx, input logic [DATA_W-1:0] value,
                                  input bit last_write);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (last_write)
        begin
            psel <= 1'b0;
            penable <= 1'b0;
            pwrite <= 1'b0;
        end
        case (idx)
            REG_LEVEL_GAIN: alpha_cfg = value[CFG_GAIN_W-1:0];
            REG_TREND_GAIN: beta_cfg = value[CFG_GAIN_W-1:0];
            REG_HOLD_TOL:   tol_cfg = value[TOL_W-1:0];
            default: ;
        endcase
    endtask

    task automatic program_registers(input logic [CFG_GAIN_W-1:0] alpha,
                                     input logic [CFG_GAIN_W-1:0] beta,
                                     input logic [TOL_W-1:0] tol);
        write_register(REG_LEVEL_GAIN, DATA_W'(alpha), 1'b0);
        write_register(REG_TREND_GAIN, DATA_W'(beta), 1'b0);
        write_register(REG_HOLD_TOL, DATA_W'(tol), 1'b1);
    endtask

    // Valid stays high after a transfer when the next sample follows without a gap.
    task automatic send_sample(input sample_vec_t s);
        int gap;
        gap = pick_gap(tx_quiet);
        if (gap > 0)
        begin
            samples_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        samples_ch.valid <= 1'b1;
        samples_ch.sample_0 <= s[0];
        samples_ch.sample_1 <= s[1];
        samples_ch.sample_2 <= s[2];
        samples_ch.sample_3 <= s[3];
        @(posedge clk);
        while (!samples_ch.ready)
            @(posedge clk);
        advance_smoother(s);
    endtask

    task automatic wait_drained();
        samples_ch.valid <= 1'b0;
        while (expected_levels.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_directed_extremes();
        send_sample(make_vec(32767, -32768, 0, -1));
        send_sample(make_vec(-32768, 32767, 1, 0));
        send_sample(make_vec(32767, -32768, -32768, 32767));
        send_sample(make_vec(0, 0, 0, 0));
        send_sample(make_vec(-1, 1, -32768, 32767));
        send_sample(make_vec(32767, 32767, 32767, 32767));
        send_sample(make_vec(-32768, -32768, -32768, -32768));
        send_sample(make_vec(32767, 32767, -32768, -32768));
    endtask

    task automatic test_gain_corners();
        int k;
        wait_drained();
        // Zero gains: each blend takes only its second operand.
        program_registers(16'd0, 16'd0, '0);
        for (k = 0; k < 3; k++)
            send_sample(make_vec(1000 * k, -1000 * k, 32767, -32768));
        wait_drained();
        program_registers(16'hFFFF, 16'd1, '0);
        for (k = 0; k < 3; k++)
            send_sample(make_vec(-32768, 12345 - k, 32767 - k, k));
        wait_drained();
        program_registers(16'd1, 16'hFFFF, '0);
        for (k = 0; k < 3; k++)
            send_sample(make_vec(-5 * k, 32767, -32768, 100 * k));
        wait_drained();
        // A write beyond the register map must change nothing.
        write_register(REG_UNMAPPED, '1, 1'b1);
        send_sample(make_vec(7, -7, 300, -300));
        send_sample(make_vec(32767, -32768, 0, -1));
    endtask

    task automatic test_hold_tolerance();
        sample_vec_t s;
        int          k;
        int          lane;
        wait_drained();
        program_registers(16'd40000, 16'd20000, 32'd3 << 16);
        for (k = 0; k < 14; k++)
        begin
            for (lane = 0; lane < MAX_LANES; lane++)
                s[lane] = 16'(1000 * lane - 1500 + int'($urandom_range(2)) - 1);
            send_sample(s);
        end
        wait_drained();
        program_registers(16'd32768, 16'd32768, '1);
        for (k = 0; k < 8; k++)
            send_sample(next_random_sample());
        wait_drained();
        // A tolerance of one holds only when the level does not move at all.
        program_registers(16'hFFFF, 16'd1, 32'd1);
        for (k = 0; k < 6; k++)
            send_sample(make_vec(-200, 200, 7, -7));
    endtask

    task automatic test_backpressure();
        int k;
        wait_drained();
        tx_quiet = 1'b1;
        rx_hold_req++;
        for (k = 0; k < 16; k++)
            send_sample(next_random_sample());
        tx_quiet = 1'b0;
    endtask

    task automatic test_random_phases();
        int p;
        int k;
        for (p = 0; p < 8; p++)
        begin
            wait_drained();
            tx_quiet = (p == 2) || ($urandom_range(4) == 0);
            rx_quiet = (p == 2) || ($urandom_range(4) == 0);
            case (p)
                0: program_registers(16'd1, 16'd1, random_tolerance());
                1: program_registers(16'hFFFF, 16'hFFFF, '0);
                default: program_registers(random_gain(), random_gain(), random_tolerance());
            endcase
            for (k = 0; k < 82; k++)
                send_sample(next_random_sample());
        end
        tx_quiet = 1'b0;
        rx_quiet = 1'b0;
    endtask

    // Output side: random stalls plus the long hold-off the pressure test asks for.
    always @(posedge clk)
    begin
        if (!rst_n)
            rx_ready <= 1'b0;
        else if (rx_hold_req != rx_hold_ack)
        begin
            rx_hold_ack = rx_hold_req;
            rx_stall_left = HOLD_OFF_LEN;
            rx_ready <= 1'b0;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            rx_ready <= 1'b0;
        end
        else
        begin
            rx_stall_left = pick_gap(rx_quiet);
            rx_ready <= (rx_stall_left == 0);
        end
    end

    always @(posedge clk)
    begin
        level_vec_t want;
        level_vec_t got;
        int         lane;
        if (rst_n && levels_ch.valid && rx_ready)
        begin
            got = {levels_ch.level_3, levels_ch.level_2, levels_ch.level_1, levels_ch.level_0};
            if (expected_levels.size() == 0)
            begin
                error_count++;
                $display("%0t: level transfer with no sample outstanding, actual %h",
                         $time, got);
            end
            else
            begin
                want = expected_levels.pop_front();
                for (lane = 0; lane < MAX_LANES; lane++)
                    if (got[lane] !== want[lane])
                    begin
                        error_count++;
                        $display("%0t: level_%0d expected %0d (%h) actual %0d (%h)",
                                 $time, lane, $signed(want[lane]), want[lane],
                                 $signed(got[lane]), got[lane]);
                    end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    initial
    begin
        samples_ch.valid <= 1'b0;
        samples_ch.sample_0 <= '0;
        samples_ch.sample_1 <= '0;
        samples_ch.sample_2 <= '0;
        samples_ch.sample_3 <= '0;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_directed_extremes();
        test_gain_corners();
        test_hold_tolerance();
        test_backpressure();
        test_random_phases();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

/* sim.f */
+incdir+src
src/vhts_pkg.sv
src/vhts_sample_if.sv
src/vhts_level_if.sv
src/vhts_regs.sv
src/vhts_ctrl.sv
src/vhts_dp.sv
src/vector_holt_trend_smoother.sv
sim/tb_vector_holt_trend_smoother.sv
